### design/ip6p_pkg.sv
// ----------------------------------------------------------------------------
// IPv6 text parser package
// Shared types, character codes, hex decode, reset state and the group commit function.
// ----------------------------------------------------------------------------
`default_nettype none

package ip6p_pkg;

  localparam int unsigned NUM_GROUPS = 8;
  localparam int unsigned GROUP_W    = 16;
  localparam int unsigned ADDR_W     = NUM_GROUPS * GROUP_W;
  localparam int unsigned HALF_W     = ADDR_W / 2;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [7:0] PREFIX_DEFAULT = 8'd64;
  localparam logic [7:0] PREFIX_MAX     = 8'd128;
  localparam logic [7:0] PREFIX_SAT     = 8'd255;
  localparam logic [3:0] GROUP_CNT_MAX  = 4'd8;

  typedef enum logic [1:0] {
    PH_GROUPS = 2'd0,
    PH_SLASH  = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_CLAMPED = 2'd2
  } status_t;

  typedef struct packed {
    logic [NUM_GROUPS-1:0][GROUP_W-1:0] grp;
    logic [3:0]  prior;
    logic [3:0]  after;
    logic        gap;
    logic [16:0] gv;     // bit 16 is a sticky overflow
    logic [1:0]  run;
    phase_t      phase;
    logic [7:0]  prefix;
    logic        err;
  } parse_state_t;

  typedef struct packed {
    logic [HALF_W-1:0] addr_high;
    logic [HALF_W-1:0] addr_low;
    logic [HALF_W-1:0] net_high;
    logic [HALF_W-1:0] net_low;
    logic [7:0]        prefix_len;
    status_t           status;
  } parse_result_t;

  function automatic parse_state_t reset_state();
    parse_state_t s;
    s        = '0;
    s.phase  = PH_GROUPS;
    s.prefix = PREFIX_DEFAULT;
    return s;
  endfunction

  // {valid, value} for 0-9, a-f, A-F
  function automatic logic [4:0] hex_decode(input logic [7:0] ch);
    logic [4:0] r;
    r = '0;
    if (ch inside {[8'h30:8'h39]}) begin
      r = {1'b1, ch[3:0]};
    end else if (ch inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b1, ch[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Closes the open group. On overflow the error is raised and parsing stops.
  function automatic parse_state_t commit_group(input parse_state_t s);
    parse_state_t n;
    logic [GROUP_W-1:0] g;
    n = s;
    g = s.gv[GROUP_W-1:0];
    if (s.gv[16]) begin
      n.err   = 1'b1;
      n.phase = PH_DONE;
    end else begin
      n.gv = '0;
      if (!s.gap) begin
        if (s.prior < GROUP_CNT_MAX) begin
          n.grp[s.prior[2:0]] = g;
          n.prior             = s.prior + 4'd1;
        end
      end else begin
        // right-aligned tail: shift the groups after the gap up one slot
        for (int j = 0; j < NUM_GROUPS - 1; j++) begin
          if (5'(j) + {1'b0, s.after} >= 5'd7) begin
            n.grp[j] = s.grp[j+1];
          end
        end
        n.grp[NUM_GROUPS-1] = g;
        if (s.after < GROUP_CNT_MAX) begin
          n.after = s.after + 4'd1;
        end
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### design/ipv6_text_address_parser.sv
// ----------------------------------------------------------------------------
// IPv6 text address parser
// Parses IPv6 address text with optional /prefix into address and subnet.
// ----------------------------------------------------------------------------
// The block takes one character per cycle while in_stall is low, with
// last_char marking the end of a text, and returns one result per text: the
// 128-bit address split into two 64-bit halves, the same address masked to
// its prefix, the prefix length and a status code. Characters are registered
// on input, the parse state and the finished result are updated by one step
// of logic, and the result sits in an output register. Only a last character
// waits in the input register while an earlier result is still stalled
// at the output. After each result the parser is back in its start state
// for the next text.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6_text_address_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_last_char,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_addr_high,
  output logic [63:0]      out_addr_low,
  output logic [63:0]      out_net_high,
  output logic [63:0]      out_net_low,
  output logic [7:0]       out_prefix_len,
  output logic [1:0]       out_status
);

  logic                    in_vld_r;
  logic [7:0]              char_r;
  logic                    last_r;
  ip6p_pkg::parse_state_t  st_r;
  ip6p_pkg::parse_state_t  st_nxt;
  ip6p_pkg::parse_result_t res_nxt;
  ip6p_pkg::parse_result_t res_r;
  logic                    out_vld_r;
  logic                    adv;
  logic                    in_xfer;

  ip6p_step u_step (
    .cur       (st_r),
    .char_code (char_r),
    .st_nxt    (st_nxt),
    .res_nxt   (res_nxt)
  );

  // a last character may only move on when the output register can take it
  assign adv     = in_vld_r && !(last_r && out_vld_r && out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_xfer = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= ip6p_pkg::reset_state();
    end else begin
      if (in_xfer) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        st_r <= last_r ? ip6p_pkg::reset_state() : st_nxt;
      end
      if (adv && last_r) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      char_r <= in_char_code;
      last_r <= in_last_char;
    end
    if (adv && last_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_addr_high  = res_r.addr_high;
  assign out_addr_low   = res_r.addr_low;
  assign out_net_high   = res_r.net_high;
  assign out_net_low    = res_r.net_low;
  assign out_prefix_len = res_r.prefix_len;
  assign out_status     = res_r.status;

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last_r) |=> (out_vld_r && st_r.phase == ip6p_pkg::PH_GROUPS
                         && st_r.prior == 4'd0 && !st_r.gap && !st_r.err))
    else $error("parser not restarted after a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |-> !(adv && last_r))
    else $error("stalled result overwritten");

  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.err |-> (st_r.phase == ip6p_pkg::PH_DONE))
    else $error("error raised while still parsing");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.status == ip6p_pkg::ST_INVALID) |->
      (res_r.addr_high == '0 && res_r.addr_low == '0 && res_r.prefix_len == 8'd0))
    else $error("invalid result carries data");

  a_prefix_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (res_r.prefix_len <= ip6p_pkg::PREFIX_MAX))
    else $error("prefix length out of range");

endmodule

`default_nettype wire

### design/ip6p_step.sv
// ----------------------------------------------------------------------------
// IPv6 text parser step
// Next parse state for one character, and the result it would close with.
// ----------------------------------------------------------------------------
`default_nettype none

module ip6p_step (
  input  wire ip6p_pkg::parse_state_t  cur,
  input  wire logic [7:0]              char_code,
  output ip6p_pkg::parse_state_t       st_nxt,
  output ip6p_pkg::parse_result_t      res_nxt
);

  ip6p_pkg::parse_state_t s;
  ip6p_pkg::parse_state_t fin;
  ip6p_pkg::parse_state_t c_commit;
  logic [4:0]  hex;
  logic        dec_ok;
  logic [3:0]  dec_val;
  logic [11:0] pmul;
  logic [7:0]  plen;
  logic [ip6p_pkg::ADDR_W-1:0] addr;
  logic [ip6p_pkg::ADDR_W-1:0] mask;

  assign hex      = ip6p_pkg::hex_decode(char_code);
  assign dec_ok   = (char_code inside {[8'h30:8'h39]});
  assign dec_val  = char_code[3:0];
  assign c_commit = ip6p_pkg::commit_group(cur);
  assign pmul     = 12'({cur.prefix, 3'b000}) + 12'({cur.prefix, 1'b0}) + 12'(dec_val);

  always_comb begin
    s = cur;
    case (cur.phase)
      ip6p_pkg::PH_GROUPS: begin
        if (hex[4]) begin
          s.gv  = {cur.gv[16] | (cur.gv[15:12] != 4'd0), cur.gv[11:0], hex[3:0]};
          s.run = 2'd0;
        end else if (char_code == ip6p_pkg::CH_COLON) begin
          case (cur.run)
            2'd0: begin
              s = c_commit;
              if (!c_commit.err) begin
                s.run = 2'd1;
                // full address without a gap: a colon ends parsing
                if (!c_commit.gap && c_commit.prior >= ip6p_pkg::GROUP_CNT_MAX) begin
                  s.phase = ip6p_pkg::PH_DONE;
                end
              end
            end
            2'd1: begin
              if (cur.gap) begin
                s.err   = 1'b1;
                s.phase = ip6p_pkg::PH_DONE;
              end else begin
                s.gap = 1'b1;
                s.run = 2'd2;
              end
            end
            default: begin
              s.err   = 1'b1;
              s.phase = ip6p_pkg::PH_DONE;
            end
          endcase
        end else begin
          s = c_commit;
          if (!c_commit.err) begin
            s.phase = (char_code == ip6p_pkg::CH_SLASH) ? ip6p_pkg::PH_SLASH
                                                        : ip6p_pkg::PH_DONE;
          end
        end
      end
      ip6p_pkg::PH_SLASH: begin
        if (dec_ok) begin
          s.prefix = {4'd0, dec_val};
          s.phase  = ip6p_pkg::PH_DIGITS;
        end else begin
          s.prefix = 8'd0;
          s.phase  = ip6p_pkg::PH_DONE;
        end
      end
      ip6p_pkg::PH_DIGITS: begin
        if (dec_ok) begin
          s.prefix = (pmul > 12'(ip6p_pkg::PREFIX_SAT)) ? ip6p_pkg::PREFIX_SAT : pmul[7:0];
        end else begin
          s.phase = ip6p_pkg::PH_DONE;
        end
      end
      default: begin
        s = cur;
      end
    endcase
  end

  assign st_nxt = s;

  // closing commit of the open group when the text ends inside the groups
  assign fin = (s.phase == ip6p_pkg::PH_GROUPS && !s.err) ? ip6p_pkg::commit_group(s) : s;

  assign addr = {fin.grp[0], fin.grp[1], fin.grp[2], fin.grp[3],
                 fin.grp[4], fin.grp[5], fin.grp[6], fin.grp[7]};

  always_comb begin
    for (int i = 0; i < ip6p_pkg::ADDR_W; i++) begin
      mask[ip6p_pkg::ADDR_W-1-i] = (8'(i) < plen);
    end
  end

  assign plen = (fin.prefix > ip6p_pkg::PREFIX_MAX) ? ip6p_pkg::PREFIX_MAX : fin.prefix;

  always_comb begin
    res_nxt = '0;
    if (fin.err) begin
      res_nxt.status = ip6p_pkg::ST_INVALID;
    end else begin
      res_nxt.addr_high  = addr[ip6p_pkg::ADDR_W-1:ip6p_pkg::HALF_W];
      res_nxt.addr_low   = addr[ip6p_pkg::HALF_W-1:0];
      res_nxt.net_high   = addr[ip6p_pkg::ADDR_W-1:ip6p_pkg::HALF_W]
                           & mask[ip6p_pkg::ADDR_W-1:ip6p_pkg::HALF_W];
      res_nxt.net_low    = addr[ip6p_pkg::HALF_W-1:0] & mask[ip6p_pkg::HALF_W-1:0];
      res_nxt.prefix_len = plen;
      res_nxt.status     = (fin.prefix > ip6p_pkg::PREFIX_MAX) ? ip6p_pkg::ST_CLAMPED
                                                               : ip6p_pkg::ST_OK;
    end
  end

endmodule

`default_nettype wire

### verif/tb_ipv6_text_address_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 text address parser testbench
// Feeds address text one character per transfer, predicts the parsed address,
// subnet, prefix and status of each text, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_ipv6_text_address_parser;
  import ip6p_pkg::*;

  localparam int STUCK_LIMIT  = 2000;
  localparam int TOTAL_CHARS  = 1300;
  localparam int QUIET_CHARS  = 150;

  typedef struct {
    logic [7:0] code;
    logic       last;
    int         idle_after;
    bit         drain_first;
    bit         quiet;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_code = '0;
  logic        in_last_char = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_addr_high;
  logic [63:0] out_addr_low;
  logic [63:0] out_net_high;
  logic [63:0] out_net_low;
  logic [7:0]  out_prefix_len;
  logic [1:0]  out_status;

  text_char_t    text_chars_q[$];
  parse_result_t expected_addr_q[$];
  logic [7:0]    draft[$];
  text_char_t    next_char;
  parse_result_t want;

  int fail_count   = 0;
  int chars_queued = 0;
  int idle_odds    = 0;
  bit quiet_mode   = 1'b0;
  bit drain_next   = 1'b0;

  // predicted parser state
  logic [15:0] slot [8];
  logic [3:0]  lead_cnt;
  logic [3:0]  tail_cnt;
  bit          gap_open;
  logic [16:0] grp_acc;
  logic [1:0]  colon_cnt;
  phase_t      phase;
  logic [7:0]  pfx_acc;
  bit          bad_text;

  always #1 clk = ~clk;

  ipv6_text_address_parser dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .in_last_char   (in_last_char),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_addr_high  (out_addr_high),
    .out_addr_low   (out_addr_low),
    .out_net_high   (out_net_high),
    .out_net_low    (out_net_low),
    .out_prefix_len (out_prefix_len),
    .out_status     (out_status)
  );

  function automatic void restart_parser();
    foreach (slot[j]) slot[j] = '0;
    lead_cnt  = '0;
    tail_cnt  = '0;
    gap_open  = 1'b0;
    grp_acc   = '0;
    colon_cnt = '0;
    phase     = PH_GROUPS;
    pfx_acc   = PREFIX_DEFAULT;
    bad_text  = 1'b0;
  endfunction

  function automatic int hex_digit(logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return int'(ch - "0");
    if (ch >= "a" && ch <= "f") return int'(ch - "a") + 10;
    if (ch >= "A" && ch <= "F") return int'(ch - "A") + 10;
    return -1;
  endfunction

  // Closes the open group; 0 on overflow.
  function automatic bit close_group();
    logic [15:0] g;
    int lo;
    g = grp_acc[15:0];
    if (grp_acc[16]) begin
      bad_text = 1'b1;
      phase = PH_DONE;
      return 1'b0;
    end
    grp_acc = '0;
    if (!gap_open) begin
      if (lead_cnt < GROUP_CNT_MAX) begin
        slot[lead_cnt[2:0]] = g;
        lead_cnt++;
      end
    end else begin
      // groups after the gap stay right-aligned, oldest drop off the top
      lo = (tail_cnt >= 4'd7) ? 0 : 7 - int'(tail_cnt);
      for (int j = lo; j < 7; j++) slot[j] = slot[j+1];
      slot[7] = g;
      if (tail_cnt < GROUP_CNT_MAX) tail_cnt++;
    end
    return 1'b1;
  endfunction

  function automatic void take_prefix_digit(logic [7:0] ch);
    int v;
    if (ch >= "0" && ch <= "9") begin
      v = int'(pfx_acc) * 10 + int'(ch - "0");
      pfx_acc = (v > 255) ? PREFIX_SAT : 8'(v);
    end else begin
      phase = PH_DONE;
    end
  endfunction

  function automatic void advance_parser(logic [7:0] ch, logic last);
    int d;
    int p;
    logic [63:0] mhi;
    logic [63:0] mlo;
    parse_result_t r;
    d = hex_digit(ch);
    case (phase)
      PH_GROUPS: begin
        if (d >= 0) begin
          grp_acc = {grp_acc[16] | (grp_acc[15:12] != 4'd0), grp_acc[11:0], 4'(d)};
          colon_cnt = 2'd0;
        end else if (ch == CH_COLON) begin
          if (colon_cnt == 2'd0) begin
            if (close_group()) begin
              colon_cnt = 2'd1;
              if (!gap_open && lead_cnt >= GROUP_CNT_MAX) phase = PH_DONE;
            end
          end else if (colon_cnt == 2'd1 && !gap_open) begin
            gap_open = 1'b1;
            colon_cnt = 2'd2;
          end else begin
            // second gap or triple colon
            bad_text = 1'b1;
            phase = PH_DONE;
          end
        end else if (close_group()) begin
          phase = (ch == CH_SLASH) ? PH_SLASH : PH_DONE;
        end
      end
      PH_SLASH: begin
        pfx_acc = '0;
        phase = PH_DIGITS;
        take_prefix_digit(ch);
      end
      PH_DIGITS: take_prefix_digit(ch);
      default: ;
    endcase
    if (last) begin
      if (phase == PH_GROUPS && !bad_text) void'(close_group());
      r = '0;
      r.status = ST_INVALID;
      if (!bad_text) begin
        r.addr_high  = {slot[0], slot[1], slot[2], slot[3]};
        r.addr_low   = {slot[4], slot[5], slot[6], slot[7]};
        r.prefix_len = pfx_acc;
        r.status     = ST_OK;
        if (pfx_acc > PREFIX_MAX) begin
          r.prefix_len = PREFIX_MAX;
          r.status     = ST_CLAMPED;
        end
        p = int'(r.prefix_len);
        mhi = (p >= 64) ? ~64'd0 : (p > 0) ? ~64'd0 << (64 - p) : 64'd0;
        mlo = (p >= 128) ? ~64'd0 : (p > 64) ? ~64'd0 << (128 - p) : 64'd0;
        r.net_high = r.addr_high & mhi;
        r.net_low  = r.addr_low & mlo;
      end
      expected_addr_q.push_back(r);
      restart_parser();
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %h, got %h", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  // ---- stimulus building ----
  function automatic void push_char(logic [7:0] code, logic last);
    text_char_t c;
    c.code        = code;
    c.last        = last;
    c.drain_first = drain_next;
    c.quiet       = quiet_mode;
    c.idle_after  = 0;
    if (!quiet_mode && idle_odds != 0 && $urandom_range(idle_odds) == 0)
      c.idle_after = $urandom_range(17, 1);
    drain_next = 1'b0;
    text_chars_q.push_back(c);
    chars_queued++;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endfunction

  function automatic void push_draft();
    foreach (draft[i]) push_char(draft[i], i == draft.size() - 1);
    draft.delete();
  endfunction

  function automatic void add_group();
    int n;
    int v;
    n = ($urandom_range(19) == 0) ? 5 : $urandom_range(4);
    repeat (n) begin
      v = $urandom_range(15);
      if (v < 10) draft.push_back(8'("0" + v));
      else if ($urandom_range(1) != 0) draft.push_back(8'("a" + v - 10));
      else draft.push_back(8'("A" + v - 10));
    end
  endfunction

  function automatic void push_random_text();
    int kind;
    int lead;
    int tail;
    bit with_gap;
    string ps;
    kind = $urandom_range(9);
    idle_odds = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 2);
    if (kind == 0) begin
      repeat ($urandom_range(6, 1)) draft.push_back(8'($urandom_range(255)));
    end else begin
      lead = $urandom_range(8);
      tail = $urandom_range(9);
      with_gap = (lead < 8) ? ($urandom_range(3) != 0) : ($urandom_range(4) == 0);
      for (int g = 0; g < lead; g++) begin
        if (g != 0) draft.push_back(CH_COLON);
        add_group();
      end
      if (with_gap) begin
        draft.push_back(CH_COLON);
        draft.push_back(CH_COLON);
        for (int g = 0; g < tail; g++) begin
          if (g != 0) draft.push_back(CH_COLON);
          add_group();
        end
      end
      if ($urandom_range(2) != 0) begin
        draft.push_back(CH_SLASH);
        case ($urandom_range(5))
          0: ;
          1: ps = $sformatf("%0d", $urandom_range(999));
          default: ps = $sformatf("%0d", $urandom_range(140));
        endcase
        for (int i = 0; i < ps.len(); i++) draft.push_back(ps[i]);
      end
      // broken texts: a stray character or colon somewhere
      if (kind == 1 && draft.size() != 0) begin
        draft.insert($urandom_range(draft.size() - 1),
                     ($urandom_range(1) != 0) ? CH_COLON : 8'($urandom_range(255)));
      end
    end
    if (draft.size() == 0) draft.push_back("0");
    push_draft();
  endfunction

  // ---- sender ----
  int idle_left = 0;
  bit in_taken  = 1'b0;
  bit quiet_tail = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (idle_left > 0) begin
        idle_left--;
        in_valid <= 1'b0;
      end else if (text_chars_q.size() == 0 ||
                   (text_chars_q[0].drain_first && expected_addr_q.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        next_char = text_chars_q.pop_front();
        in_valid     <= 1'b1;
        in_char_code <= next_char.code;
        in_last_char <= next_char.last;
        quiet_tail   <= next_char.quiet;
        idle_left = next_char.idle_after;
      end
    end
  end

  // ---- receiver back-pressure ----
  int stall_left = 0;
  int cycle_cnt  = 0;
  bit rx_choppy  = 1'b1;

  always @(negedge clk) begin
    cycle_cnt++;
    if (cycle_cnt % 64 == 0) rx_choppy = ($urandom_range(2) != 0);
    if (stall_left == 0 && !quiet_tail && rx_choppy && $urandom_range(5) == 0)
      stall_left = $urandom_range(17, 1);
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---- monitor and checker ----
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      in_taken = in_valid && !in_stall;
      if (in_taken) advance_parser(in_char_code, in_last_char);
      if (out_valid && !out_stall) begin
        if (expected_addr_q.size() == 0) begin
          $error("result with none expected: addr %h%h status %0d",
                 out_addr_high, out_addr_low, out_status);
          fail_count++;
        end else begin
          want = expected_addr_q.pop_front();
          check_field("addr_high", want.addr_high, out_addr_high);
          check_field("addr_low", want.addr_low, out_addr_low);
          check_field("net_high", want.net_high, out_net_high);
          check_field("net_low", want.net_low, out_net_low);
          check_field("prefix_len", 64'(want.prefix_len), 64'(out_prefix_len));
          check_field("status", 64'(want.status), 64'(out_status));
        end
      end
      stuck_cycles = (in_taken || (out_valid && !out_stall)) ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("ipv6_text_address_parser test failed");
        $finish;
      end
    end
  end

  initial begin
    restart_parser();
    idle_odds = 4;
    push_text("::");
    push_text("a::B:c");
    push_text("1::2::3");
    push_text(":::");
    push_text("12345::");
    push_text("1:2:3:4:5:6:7:8:9");
    push_text("Ff:0:0:0:0:0:0:e/200");
    push_text("::1:2:3:4:5:6:7:8:9");
    push_text("fe80::1/");
    push_text("ab/x7");
    push_text("2001:db8::/48");
    push_text("1:2 x:y");
    push_text("/129");
    push_text("ffff:FFFF::ffff/128");
    push_char(8'h00, 1'b1);
    push_char(8'hFF, 1'b1);
    push_char("1", 1'b0);
    push_char(8'hFF, 1'b0);
    push_char(CH_COLON, 1'b1);
    for (int n = 0; chars_queued < TOTAL_CHARS; n++) begin
      quiet_mode = (chars_queued > TOTAL_CHARS - QUIET_CHARS);
      if (n % 25 == 0) drain_next = 1'b1;
      push_random_text();
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (text_chars_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_addr_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ipv6_text_address_parser test passed");
    end else begin
      $display("ipv6_text_address_parser test failed");
    end
    $finish;
  end

endmodule

### files.f
design/ip6p_pkg.sv
design/ip6p_step.sv
design/ipv6_text_address_parser.sv
verif/tb_ipv6_text_address_parser.sv
